@@ rtl/dplc_pkg.sv @@
// ----------------------------------------------------------------------------
// dplc_pkg: shared types and constants for the press-length classifier
// Register indexes, reset values, field widths and the press-kind codes.
// ----------------------------------------------------------------------------
package dplc_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned INTEG_W    = 8;
  localparam int unsigned HOLD_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_TICKS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TICKS = 2'd2;

  localparam logic [INTEG_W-1:0] DEBOUNCE_TICKS_RST   = 8'd5;
  localparam logic [HOLD_W-1:0]  PRESS_TICKS_RST      = 16'd500;
  localparam logic [HOLD_W-1:0]  LONG_PRESS_TICKS_RST = 16'd1000;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_SHORT  = 2'd1,
    KIND_MEDIUM = 2'd2,
    KIND_LONG   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [INTEG_W-1:0] debounce_ticks;
    logic [HOLD_W-1:0]  press_ticks;
    logic [HOLD_W-1:0]  long_press_ticks;
  } cfg_t;

endpackage

@@ rtl/dplc_intf.sv @@
// ----------------------------------------------------------------------------
// dplc channel interfaces
// Valid/ready channels for raw ticks, classified results and register writes.
// ----------------------------------------------------------------------------
interface dplc_in_if;
  logic valid;
  logic ready;
  logic button_down;

  modport source (output valid, output button_down, input ready);
  modport sink (input valid, input button_down, output ready);
endinterface

interface dplc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] press_kind;
  logic       clean_level;

  modport source (output valid, output press_kind, output clean_level, input ready);
  modport sink (input valid, input press_kind, input clean_level, output ready);
endinterface

interface dplc_cfg_if import dplc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/dplc_debounce.sv @@
// ----------------------------------------------------------------------------
// dplc_debounce: integrating debouncer
// Saturating up/down integrator; the clean level sets at the top, clears at 0.
// ----------------------------------------------------------------------------
module dplc_debounce import dplc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic               button_down,
  input  logic [INTEG_W-1:0] debounce_ticks,
  output logic               level_nxt
);

  logic [INTEG_W-1:0] integ_r, integ_nxt;
  logic               level_r;

  always_comb begin
    if ((integ_r < debounce_ticks) && button_down) begin
      integ_nxt = integ_r + INTEG_W'(1);
    end else if ((integ_r != '0) && !button_down) begin
      integ_nxt = integ_r - INTEG_W'(1);
    end else begin
      integ_nxt = integ_r;
    end

    // Zero wins over the top so a zero top keeps the level released.
    if (integ_nxt == '0) begin
      level_nxt = 1'b0;
    end else if (integ_nxt == debounce_ticks) begin
      level_nxt = 1'b1;
    end else begin
      level_nxt = level_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      level_r <= 1'b0;
    end else if (step) begin
      integ_r <= integ_nxt;
      level_r <= level_nxt;
    end
  end

endmodule

@@ rtl/dplc_classifier.sv @@
// ----------------------------------------------------------------------------
// dplc_classifier: press-length state machine
// Times each clean press and reports short, medium or long.
// ----------------------------------------------------------------------------
module dplc_classifier import dplc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step,
  input  logic  pressed,
  input  cfg_t  cfg,
  output kind_t kind
);

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SHORT  = 2'd1,
    PH_MEDIUM = 2'd2,
    PH_LONG   = 2'd3
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [HOLD_W-1:0]   hold_r, hold_nxt;
  logic [HOLD_W-1:0]   hold_inc;

  // The hold counter saturates instead of wrapping.
  assign hold_inc = (hold_r == '1) ? hold_r : hold_r + HOLD_W'(1);

  always_comb begin
    phase_nxt = phase_r;
    hold_nxt  = hold_r;
    kind      = KIND_NONE;
    unique case (phase_r)
      PH_IDLE: begin
        // The onset tick clears the counter and is not itself counted.
        if (pressed) begin
          phase_nxt = PH_SHORT;
          hold_nxt  = '0;
        end
      end
      PH_SHORT: begin
        hold_nxt = hold_inc;
        if (!pressed) begin
          phase_nxt = PH_IDLE;
          kind      = KIND_SHORT;
        end else if (hold_inc >= cfg.press_ticks) begin
          phase_nxt = PH_MEDIUM;
        end
      end
      PH_MEDIUM: begin
        hold_nxt = hold_inc;
        if (!pressed) begin
          phase_nxt = PH_IDLE;
          kind      = KIND_MEDIUM;
        end else if (hold_inc >= cfg.long_press_ticks) begin
          phase_nxt = PH_LONG;
          kind      = KIND_LONG;
        end
      end
      PH_LONG: begin
        if (!pressed) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      hold_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      hold_r  <= hold_nxt;
    end
  end

endmodule

@@ rtl/debounced_press_length_classifier.sv @@
// ----------------------------------------------------------------------------
// debounced_press_length_classifier: debounced button press-length detector
// Input register, debouncer and classifier logic, and an output register.
// ----------------------------------------------------------------------------
// Each input transfer is one tick of the raw button level and produces exactly
// one result transfer carrying the press kind reported on that tick and the
// debounced level after it. The block sustains one tick per clock while the
// output side is not stalled: a tick is taken into an input register, updates
// the debouncer and classifier state and lands in an output register. The
// input register and output register let a new tick be taken while a result
// waits. Register writes are taken every cycle and are meant to happen only
// while no tick is in flight.
module debounced_press_length_classifier import dplc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  dplc_in_if.sink    in_ch,
  dplc_out_if.source out_ch,
  dplc_cfg_if.sink   cfg_ch
);

  cfg_t cfg_r;

  logic  s1_valid_r, s1_down_r;
  logic  out_valid_r;
  logic  [1:0] out_kind_r;
  logic  out_level_r;
  logic  advance, step, in_ready;
  logic  level_nxt;
  kind_t kind;

  // Register file.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks   <= DEBOUNCE_TICKS_RST;
      cfg_r.press_ticks      <= PRESS_TICKS_RST;
      cfg_r.long_press_ticks <= LONG_PRESS_TICKS_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_DEBOUNCE_TICKS:   cfg_r.debounce_ticks   <= cfg_ch.data[INTEG_W-1:0];
        REG_PRESS_TICKS:      cfg_r.press_ticks      <= cfg_ch.data[HOLD_W-1:0];
        REG_LONG_PRESS_TICKS: cfg_r.long_press_ticks <= cfg_ch.data[HOLD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The held tick moves on whenever the output register is empty or drains.
  assign advance     = !out_valid_r || out_ch.ready;
  assign step        = s1_valid_r && advance;
  assign in_ready    = !s1_valid_r || advance;
  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      s1_down_r <= in_ch.button_down;
    end
  end

  dplc_debounce u_debounce (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .button_down    (s1_down_r),
    .debounce_ticks (cfg_r.debounce_ticks),
    .level_nxt      (level_nxt)
  );

  dplc_classifier u_classifier (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .pressed (level_nxt),
    .cfg     (cfg_r),
    .kind    (kind)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_kind_r  <= kind;
      out_level_r <= level_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.press_kind  = out_kind_r;
  assign out_ch.clean_level = out_level_r;

  // A long press is only reported while the clean level is still pressed.
  a_long_while_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == KIND_LONG)) |-> out_level_r)
    else $error("long press reported with clean level released");

  // Short and medium are reported on the release tick.
  a_release_kinds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ((out_kind_r == KIND_SHORT) || (out_kind_r == KIND_MEDIUM)))
      |-> !out_level_r)
    else $error("short or medium press reported while still pressed");

  // A held tick blocked by a stalled output must also block the input.
  a_stall_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted while the pipeline is full");

endmodule
